[rtl/core/vwia_pkg.sv]
// Package for the variable-width integer ALU.
// Holds the request/result types, opcodes, the pipeline stage type and helpers.
// Depends on nothing.
package vwia_pkg;

    localparam int DW    = 64;
    localparam int WW    = 7;
    localparam int NCELL = DW;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_NEG   = 5'd3,
        OP_SDIV  = 5'd4,
        OP_UDIV  = 5'd5,
        OP_SREM  = 5'd6,
        OP_UREM  = 5'd7,
        OP_AND   = 5'd8,
        OP_OR    = 5'd9,
        OP_XOR   = 5'd10,
        OP_SHL   = 5'd11,
        OP_LSHR  = 5'd12,
        OP_ASHR  = 5'd13,
        OP_SEXT  = 5'd14,
        OP_ZEXT  = 5'd15,
        OP_TRUNC = 5'd16,
        OP_EQ    = 5'd17,
        OP_NE    = 5'd18,
        OP_ULT   = 5'd19,
        OP_ULE   = 5'd20,
        OP_UGT   = 5'd21,
        OP_UGE   = 5'd22,
        OP_INC   = 5'd23,
        OP_DEC   = 5'd24
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_DIVZERO = 2'd1,
        ERR_EXTEND  = 2'd2
    } err_t;

    typedef struct packed {
        logic [4:0]    opcode;
        logic [WW-1:0] operand_width;
        logic [DW-1:0] operand_a;
        logic [DW-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic [DW-1:0] result_value;
        logic [WW-1:0] result_width;
        logic [1:0]    error_code;
    } rsp_t;

    // Control carried alongside the datapath through every cell.
    typedef struct packed {
        logic [4:0]    op;
        logic [WW-1:0] w;
        logic [WW-1:0] rw;
        logic [1:0]    err;
        logic          neg_a;
        logic          neg_b;
        logic [DW-1:0] res;
    } ctrl_t;

    typedef struct packed {
        logic          valid;
        ctrl_t         ctrl;
        logic [DW-1:0] rem;
        logic [DW-1:0] quo;
        logic [DW-1:0] dvsr;
        logic [DW-1:0] mcand;
        logic [DW-1:0] mplier;
        logic [DW-1:0] acc;
    } stage_t;

    function automatic logic [DW-1:0] width_mask(input logic [WW-1:0] w);
        logic [DW-1:0] m;
        begin
            if (w >= WW'(DW))
            begin
                m = '1;
            end
            else
            begin
                m = (DW'(1) << w[5:0]) - DW'(1);
            end
            return m;
        end
    endfunction

endpackage

[rtl/core/vwia_prep.sv]
// Front stage of the variable-width integer ALU: width clamp, operand masking,
// the ops that do not use the chain and setup of the divide/multiply cell chain. Uses vwia_pkg.
module vwia_prep #(
    parameter int LIM = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  vwia_pkg::req_t  req,
    output vwia_pkg::stage_t st
);
    import vwia_pkg::*;

    logic [WW-1:0] w, rw;
    logic [DW-1:0] m, a, b, sa, sb, res;
    logic          neg_a, neg_b, b_zero;
    logic [1:0]    err;
    logic          valid_reg;
    stage_t        st_next, st_reg;

    always_comb
    begin
        if (req.operand_width == '0)
        begin
            w = WW'(1);
        end
        else if (req.operand_width > WW'(LIM))
        begin
            w = WW'(LIM);
        end
        else
        begin
            w = req.operand_width;
        end
        m      = width_mask(w);
        a      = req.operand_a & m;
        b      = req.operand_b & m;
        neg_a  = a[6'(w - WW'(1))];
        neg_b  = b[6'(w - WW'(1))];
        sa     = neg_a ? (a | ~m) : a;
        sb     = neg_b ? (b | ~m) : b;
        b_zero = (b == '0);
        rw     = w;
        err    = ERR_OK;
        res    = '0;

        unique case (op_t'(req.opcode))
            OP_ADD:   res = a + b;
            OP_SUB:   res = a - b;
            OP_NEG:   res = DW'(0) - a;
            OP_AND:   res = a & b;
            OP_OR:    res = a | b;
            OP_XOR:   res = a ^ b;
            OP_SHL:   res = (b >= DW'(w)) ? '0 : (a << b[5:0]);
            OP_LSHR:  res = (b >= DW'(w)) ? '0 : (a >> b[5:0]);
            OP_ASHR:  res = (b >= DW'(w)) ? (neg_a ? m : '0) : (sa >> b[5:0]);
            OP_SEXT, OP_ZEXT:
            begin
                if (req.operand_b > DW'(WW'(LIM) - w))
                begin
                    err = ERR_EXTEND;
                end
                else
                begin
                    rw  = w + req.operand_b[WW-1:0];
                    res = (op_t'(req.opcode) == OP_SEXT) ? sa : a;
                end
            end
            OP_TRUNC:
            begin
                res = a;
                if (req.operand_b < DW'(w))
                begin
                    rw = (req.operand_b == '0) ? WW'(1) : req.operand_b[WW-1:0];
                end
            end
            OP_EQ:    res = DW'(a == b);
            OP_NE:    res = DW'(a != b);
            OP_ULT:   res = DW'(a < b);
            OP_ULE:   res = DW'(a <= b);
            OP_UGT:   res = DW'(a > b);
            OP_UGE:   res = DW'(a >= b);
            OP_INC:   res = a + DW'(1);
            OP_DEC:   res = a - DW'(1);
            OP_SDIV, OP_UDIV, OP_SREM, OP_UREM:
            begin
                if (b_zero)
                begin
                    err = ERR_DIVZERO;
                end
            end
            default:  res = '0;
        endcase

        st_next.valid      = in_valid;
        st_next.ctrl.op    = req.opcode;
        st_next.ctrl.w     = w;
        st_next.ctrl.rw    = rw;
        st_next.ctrl.err   = err;
        st_next.ctrl.neg_a = neg_a;
        st_next.ctrl.neg_b = neg_b;
        st_next.ctrl.res   = res;
        st_next.rem        = '0;
        // signed ops divide magnitudes; sign is restored at the tail
        if ((op_t'(req.opcode) == OP_SDIV) || (op_t'(req.opcode) == OP_SREM))
        begin
            st_next.quo  = neg_a ? (DW'(0) - sa) : sa;
            st_next.dvsr = neg_b ? (DW'(0) - sb) : sb;
        end
        else
        begin
            st_next.quo  = a;
            st_next.dvsr = b;
        end
        st_next.mcand  = a;
        st_next.mplier = b;
        st_next.acc    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    always_comb
    begin
        st       = st_reg;
        st.valid = valid_reg;
    end

endmodule

[rtl/core/vwia_cell.sv]
// One cell of the ALU chain: one restoring-divide step and one shift-add
// multiply step per cycle, registered. Uses vwia_pkg.
module vwia_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  vwia_pkg::stage_t st_in,
    output vwia_pkg::stage_t st_out
);
    import vwia_pkg::*;

    logic [DW:0]   t, diff;
    logic          ge;
    logic          valid_reg;
    stage_t        st_next, st_reg;

    always_comb
    begin
        t    = {st_in.rem, st_in.quo[DW-1]};
        diff = t - {1'b0, st_in.dvsr};
        ge   = !diff[DW];

        st_next        = st_in;
        st_next.rem    = ge ? diff[DW-1:0] : t[DW-1:0];
        st_next.quo    = {st_in.quo[DW-2:0], ge};
        st_next.acc    = st_in.acc + (st_in.mplier[0] ? st_in.mcand : '0);
        st_next.mcand  = st_in.mcand << 1;
        st_next.mplier = st_in.mplier >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= st_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    always_comb
    begin
        st_out       = st_reg;
        st_out.valid = valid_reg;
    end

endmodule

[rtl/core/variable_width_integer_alu_top.sv]
// Top level of the variable-width integer ALU: front stage, cell chain and
// result stage. Uses vwia_pkg, vwia_prep and vwia_cell.
//
// Fully pipelined: a request is taken in every cycle that start is high (busy
// is always low). Its result is on result with done high once it has passed
// 66 register stages: one front register, 64 cells and one output register.
// Each cell produces one quotient bit and one multiplier bit, so the divide
// and multiply set the chain length. Results come in request order and cannot
// be held off; the receiver must take each one in its done cycle. Division by
// zero returns 0 with error code 1. An extension past the width limit returns
// 0 with error code 2.
module variable_width_integer_alu_top #(
    parameter int MAX_WIDTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  vwia_pkg::req_t request,
    output logic           done,
    output vwia_pkg::rsp_t result
);
    import vwia_pkg::*;

    localparam int LIM = (MAX_WIDTH < DW) ? MAX_WIDTH : DW;

    stage_t        chain [0:NCELL];
    stage_t        last;
    logic [DW-1:0] val;
    rsp_t          result_next, result_reg;
    logic          done_reg;

    assign busy = 1'b0;

    vwia_prep #(
        .LIM (LIM)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .req      (request),
        .st       (chain[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            vwia_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .st_in  (chain[gi]),
                .st_out (chain[gi+1])
            );
        end
    endgenerate

    assign last = chain[NCELL];

    // Pick the chain output for divide/multiply, restore signs, mask.
    always_comb
    begin
        case (op_t'(last.ctrl.op))
            OP_MUL:  val = last.acc;
            OP_UDIV: val = last.quo;
            OP_UREM: val = last.rem;
            OP_SDIV: val = (last.ctrl.neg_a != last.ctrl.neg_b) ?
                           (DW'(0) - last.quo) : last.quo;
            OP_SREM: val = last.ctrl.neg_a ? (DW'(0) - last.rem) : last.rem;
            default: val = last.ctrl.res;
        endcase
        if (last.ctrl.err != ERR_OK)
        begin
            val = '0;
        end
        result_next.result_value = val & width_mask(last.ctrl.rw);
        result_next.result_width = last.ctrl.rw;
        result_next.error_code   = last.ctrl.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Any error forces a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.error_code != ERR_OK) |-> result.result_value == '0)
        else $error("error result with nonzero value");

    // Result width stays in 1..limit.
    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.result_width != '0) && (result.result_width <= WW'(LIM)))
        else $error("result width out of range");

    // Done follows the last cell's valid in the next cycle.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid |=> done)
        else $error("lost result at chain end");

endmodule
